FILE: sv/otsu_pkg.sv
// Shared request codes, result codes and payload widths for the Otsu threshold block.
package otsu_pkg;
   localparam int BYTE_W = 8;
   localparam int REQ_W  = 2;

   typedef logic [REQ_W-1:0]  req_code_type;
   typedef logic [BYTE_W-1:0] byte_type;

   localparam req_code_type REQ_ACC   = 2'd0;
   localparam req_code_type REQ_CALC  = 2'd1;
   localparam req_code_type REQ_APPLY = 2'd2;
   localparam req_code_type REQ_NOP   = 2'd3;

   localparam logic KIND_THR = 1'b0;
   localparam logic KIND_PIX = 1'b1;
endpackage

FILE: sv/otsu_ifs.sv
// Channel interfaces: request, response and register write.
interface otsu_req_if;
   import otsu_pkg::*;
   logic         valid;
   logic         ready;
   req_code_type req_type;
   byte_type     chan_a;
   byte_type     chan_b;
   byte_type     chan_c;
   modport source (output valid, req_type, chan_a, chan_b, chan_c, input ready);
   modport sink (input valid, req_type, chan_a, chan_b, chan_c, output ready);
endinterface

interface otsu_rsp_if;
   import otsu_pkg::*;
   logic     valid;
   logic     ready;
   logic     result_kind;
   byte_type out_value;
   modport source (output valid, result_kind, out_value, input ready);
   modport sink (input valid, result_kind, out_value, output ready);
endinterface

interface otsu_csr_if;
   import otsu_pkg::*;
   logic     valid;
   logic     ready;
   byte_type data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

FILE: sv/otsu_threshold_and_mask.sv
// Otsu threshold and mask: histogram memory, threshold search sequencer, mask output.
// Channels: req_chan takes requests (accumulate a pixel, compute threshold, apply
// mask); rsp_chan returns one result for compute and apply, none for accumulate;
// csr_chan writes preset_ff and is always ready.
// Accumulate: after acceptance, a read-modify-write on the single histogram memory
// for each of the three channel bytes (read in S_ARD, write in S_AWR).
// Apply: result appears in the output register the cycle after acceptance;
// one apply per cycle while the receiver keeps up.
// Compute: one pass over the bins sums them (S_SRD, S_SAC); a second pass (S_WRD,
// S_WAC) then, for each bin with both classes non-empty, runs six shift-add multiplies
// of one operand bit per cycle. The walk writes each bin back to zero. A nonzero
// preset skips the multiplies.
// Reset: control state clears, then a pass over every bin zeroes the histogram;
// no request is taken during that pass.
// A stalled receiver holds the output register; requests are taken again once
// it drains, accumulate included.
module otsu_threshold_and_mask #(
   parameter int BINS       = 256,
   parameter int COUNT_BITS = 22
) (
   input logic clock,
   input logic reset,
   otsu_req_if.sink   req_chan,
   otsu_rsp_if.source rsp_chan,
   otsu_csr_if.sink   csr_chan
);
   import otsu_pkg::*;

   localparam int BB = (BINS > 1) ? $clog2(BINS) : 1;
   localparam int CB = COUNT_BITS;
   localparam int SW = CB + 2 * BB;
   localparam int WW = CB + BB;
   localparam int DW = SW + CB;
   localparam int PW = 2 * DW + 2 * CB;
   localparam logic [CB-1:0] CMAX = {CB{1'b1}};
   localparam logic [BB-1:0] KLAST = BB'(BINS - 1);

   localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_ARD = 4'd2, S_AWR = 4'd3,
      S_SRD = 4'd4, S_SAC = 4'd5, S_WRD = 4'd6, S_WAC = 4'd7, S_MUL = 4'd8,
      S_DONE = 4'd9;
   localparam logic [2:0] OP_A = 3'd0, OP_B = 3'd1, OP_SQ = 3'd2, OP_DW = 3'd3,
      OP_L = 3'd4, OP_R = 3'd5;

   logic [CB-1:0] hist_mem [BINS];
   logic [CB-1:0] rdata_ff;
   logic [BB-1:0] ra, wa;
   logic          we;
   logic [CB-1:0] wd;

   logic [3:0]      state_ff, state_in;
   logic [BB-1:0]   k_ff, k_in;
   logic [1:0]      bi_ff, bi_in;
   logic [2:0][7:0] pix_ff, pix_in;
   logic [CB-1:0]   n_ff, n_in;
   logic [SW-1:0]   sum_ff, sum_in, m0_ff, m0_in;
   logic [WW-1:0]   w0_ff, w0_in;
   logic [DW-1:0]   a_ff, a_in, diff_ff, diff_in;
   logic [2*DW-1:0] num_ff, num_in, bnum_ff, bnum_in;
   logic [2*CB-1:0] dw_ff, dw_in, bden_ff, bden_in;
   logic [PW-1:0]   lhs_ff, lhs_in, mc_ff, mc_in, acc_ff, acc_in;
   logic [DW-1:0]   mp_ff, mp_in;
   logic [2:0]      op_ff, op_in;
   logic [7:0]      best_ff, best_in, thr_ff, thr_in, preset_ff;
   logic            rv_ff, rv_in, rk_ff, rk_in;
   logic [7:0]      rval_ff, rval_in;

   logic          req_ready, take, start;
   logic [2:0]    sop;
   logic [BB+CB-1:0] kh;
   logic [CB:0]   nsum;
   logic [7:0]    tsel;
   logic [DW-1:0] bprod;

   function automatic logic [BB-1:0] bin_of(input logic [7:0] v);
      if ({1'b0, v} >= 9'(BINS)) begin
         return KLAST;
      end
      return BB'(v);
   endfunction

   assign req_ready        = (state_ff == S_IDLE) && (!rv_ff || rsp_chan.ready);
   assign req_chan.ready   = req_ready;
   assign take             = req_chan.valid && req_ready;
   assign csr_chan.ready   = 1'b1;
   assign rsp_chan.valid       = rv_ff;
   assign rsp_chan.result_kind = rk_ff;
   assign rsp_chan.out_value   = rval_ff;
   assign kh   = {{CB{1'b0}}, k_ff} * {{BB{1'b0}}, rdata_ff};
   assign nsum = {1'b0, n_ff} + (CB+1)'(3);
   assign tsel = (preset_ff != 8'd0) ? preset_ff : thr_ff;
   assign bprod = acc_ff[DW-1:0];

   always_ff @(posedge clock) begin
      if (we) begin
         hist_mem[wa] <= wd;
      end
      rdata_ff <= hist_mem[ra];
   end

   always_comb begin
      state_in = state_ff; k_in = k_ff; bi_in = bi_ff; pix_in = pix_ff; n_in = n_ff;
      sum_in = sum_ff; m0_in = m0_ff; w0_in = w0_ff; a_in = a_ff; diff_in = diff_ff;
      num_in = num_ff; bnum_in = bnum_ff; dw_in = dw_ff; bden_in = bden_ff;
      lhs_in = lhs_ff; mc_in = mc_ff; acc_in = acc_ff; mp_in = mp_ff; op_in = op_ff;
      best_in = best_ff; thr_in = thr_ff;
      rv_in = rv_ff && !rsp_chan.ready; rk_in = rk_ff; rval_in = rval_ff;
      ra = k_ff; wa = k_ff; we = 1'b0; wd = '0;
      start = 1'b0; sop = OP_A;
      case (state_ff)
         S_CLR: begin
            we = 1'b1;
            k_in = k_ff + 1'b1;
            if (k_ff == KLAST) begin
               k_in = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (take) begin
               case (req_chan.req_type)
                  REQ_ACC: begin
                     pix_in = {req_chan.chan_c, req_chan.chan_b, req_chan.chan_a};
                     n_in = (nsum > {1'b0, CMAX}) ? CMAX : nsum[CB-1:0];
                     bi_in = 2'd0;
                     state_in = S_ARD;
                  end
                  REQ_CALC: begin
                     k_in = '0; sum_in = '0; w0_in = '0; m0_in = '0;
                     bnum_in = '0; bden_in = (2*CB)'(1); best_in = '0;
                     state_in = S_SRD;
                  end
                  REQ_APPLY: begin
                     rv_in = 1'b1;
                     rk_in = KIND_PIX;
                     rval_in = (req_chan.chan_b > tsel) ? req_chan.chan_a : 8'd0;
                  end
                  default: ;
               endcase
            end
         end
         S_ARD: begin
            ra = bin_of(pix_ff[bi_ff]);
            state_in = S_AWR;
         end
         S_AWR: begin
            we = 1'b1;
            wa = bin_of(pix_ff[bi_ff]);
            wd = (rdata_ff == CMAX) ? CMAX : rdata_ff + 1'b1;
            bi_in = bi_ff + 1'b1;
            state_in = (bi_ff == 2'd2) ? S_IDLE : S_ARD;
         end
         S_SRD: state_in = S_SAC;
         S_SAC: begin
            sum_in = sum_ff + SW'(kh);
            k_in = k_ff + 1'b1;
            state_in = S_SRD;
            if (k_ff == KLAST) begin
               k_in = '0;
               state_in = S_WRD;
            end
         end
         S_WRD: state_in = S_WAC;
         S_WAC: begin
            we = 1'b1;
            w0_in = w0_ff + WW'(rdata_ff);
            m0_in = m0_ff + SW'(kh);
            if (preset_ff != 8'd0 || w0_in == '0 || w0_in >= WW'(n_ff)) begin
               k_in = k_ff + 1'b1;
               state_in = (k_ff == KLAST) ? S_DONE : S_WRD;
            end else begin
               start = 1'b1; sop = OP_A;
            end
         end
         S_MUL: begin
            if (mp_ff != '0) begin
               if (mp_ff[0]) begin
                  acc_in = acc_ff + mc_ff;
               end
               mc_in = mc_ff << 1;
               mp_in = mp_ff >> 1;
            end else begin
               case (op_ff)
                  OP_A: begin
                     a_in = bprod; start = 1'b1; sop = OP_B;
                  end
                  OP_B: begin
                     diff_in = (a_ff >= bprod) ? a_ff - bprod : bprod - a_ff;
                     start = 1'b1; sop = OP_SQ;
                  end
                  OP_SQ: begin
                     num_in = acc_ff[2*DW-1:0]; start = 1'b1; sop = OP_DW;
                  end
                  OP_DW: begin
                     dw_in = acc_ff[2*CB-1:0]; start = 1'b1; sop = OP_L;
                  end
                  OP_L: begin
                     lhs_in = acc_ff; start = 1'b1; sop = OP_R;
                  end
                  default: begin
                     if (lhs_ff > acc_ff) begin
                        bnum_in = num_ff; bden_in = dw_ff; best_in = 8'(k_ff);
                     end
                     k_in = k_ff + 1'b1;
                     state_in = (k_ff == KLAST) ? S_DONE : S_WRD;
                  end
               endcase
            end
         end
         S_DONE: begin
            if (!rv_ff || rsp_chan.ready) begin
               thr_in = (preset_ff != 8'd0) ? preset_ff : best_ff;
               rv_in = 1'b1;
               rk_in = KIND_THR;
               rval_in = thr_in;
               n_in = '0;
               k_in = '0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (start) begin
         op_in = sop;
         acc_in = '0;
         state_in = S_MUL;
         case (sop)
            OP_A: begin
               mc_in = PW'(sum_ff); mp_in = DW'(w0_in[CB-1:0]);
            end
            OP_B: begin
               mc_in = PW'(n_ff); mp_in = DW'(m0_ff);
            end
            OP_SQ: begin
               mc_in = PW'(diff_in); mp_in = diff_in;
            end
            OP_DW: begin
               mc_in = PW'(w0_ff[CB-1:0]); mp_in = DW'(n_ff - w0_ff[CB-1:0]);
            end
            OP_L: begin
               mc_in = PW'(num_ff); mp_in = DW'(bden_ff);
            end
            default: begin
               mc_in = PW'(bnum_ff); mp_in = DW'(dw_ff);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         k_ff <= '0;
         n_ff <= '0;
         thr_ff <= '0;
         preset_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff <= k_in;
         n_ff <= n_in;
         thr_ff <= thr_in;
         rv_ff <= rv_in;
         if (csr_chan.valid) begin
            preset_ff <= csr_chan.data;
         end
      end
      bi_ff <= bi_in; pix_ff <= pix_in; sum_ff <= sum_in; m0_ff <= m0_in; w0_ff <= w0_in;
      a_ff <= a_in; diff_ff <= diff_in; num_ff <= num_in; bnum_ff <= bnum_in;
      dw_ff <= dw_in; bden_ff <= bden_in; lhs_ff <= lhs_in; mc_ff <= mc_in;
      acc_ff <= acc_in; mp_ff <= mp_in; op_ff <= op_in; best_ff <= best_in;
      rk_ff <= rk_in; rval_ff <= rval_in;
   end
endmodule

FILE: sv/otsu_checker.sv
// Port-level checks for the Otsu threshold block, bound to the top level.
module otsu_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_type,
   input logic [7:0] chan_a,
   input logic [7:0] chan_b,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       result_kind,
   input logic [7:0] out_value
);
   import otsu_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_value) && $stable(result_kind))
      else $error("response changed while stalled");

   a_acc_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_type == REQ_ACC && !rsp_valid |=> !rsp_valid)
      else $error("accumulate produced a response");

   a_apply_zero: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_type == REQ_APPLY && (chan_b == 8'd0 || chan_a == 8'd0)
      |=> rsp_valid && result_kind == KIND_PIX && out_value == 8'd0)
      else $error("masked pixel not zero");

   a_apply_next: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_type == REQ_APPLY |=> rsp_valid && result_kind == KIND_PIX)
      else $error("apply response missing");
endmodule

bind otsu_threshold_and_mask otsu_checker u_otsu_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .req_type(req_chan.req_type),
   .chan_a(req_chan.chan_a),
   .chan_b(req_chan.chan_b),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .result_kind(rsp_chan.result_kind),
   .out_value(rsp_chan.out_value)
);

FILE: tb/testbench.sv
// Self-checking testbench for the Otsu threshold and mask block.
`timescale 1ns / 100ps

module testbench;
   import otsu_pkg::*;

   localparam int NUM_BINS  = 256;
   localparam int CNT_W     = 22;
   localparam int SETTLE    = 40;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   typedef struct {
      req_code_type code;
      byte_type     a;
      byte_type     b;
      byte_type     c;
   } pixel_req_type;

   typedef struct {
      logic     kind;
      byte_type value;
   } mask_result_type;

   logic clock;
   logic reset;

   otsu_req_if req_bus ();
   otsu_rsp_if rsp_bus ();
   otsu_csr_if csr_bus ();

   otsu_threshold_and_mask dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   pixel_req_type   pending_reqs[$];
   mask_result_type expected_results[$];
   pixel_req_type   cur_req;

   logic [CNT_W-1:0] hist_model [NUM_BINS];
   logic [CNT_W-1:0] pixel_total;
   byte_type         thr_model;
   byte_type         preset_model;

   int  send_idle_pct;
   int  rsp_stall_pct;
   int  error_count;
   int  hold_left;
   bit  hold_arm;
   bit  hold_done;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #200_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic void count_byte(input byte_type v);
      if (hist_model[v] != CNT_MAX) hist_model[v] = hist_model[v] + 1'b1;
   endfunction

   function automatic byte_type otsu_search();
      logic [63:0]  n, sum_all, w0, m0;
      logic [255:0] a, b, diff, num, den, best_num, best_den;
      byte_type     best;
      n = 64'(pixel_total);
      sum_all = '0;
      w0 = '0;
      m0 = '0;
      best_num = '0;
      best_den = 256'd1;
      best = '0;
      for (int k = 0; k < NUM_BINS; k++) sum_all += 64'(k) * 64'(hist_model[k]);
      for (int k = 0; k < NUM_BINS; k++) begin
         w0 += 64'(hist_model[k]);
         m0 += 64'(k) * 64'(hist_model[k]);
         if (w0 == 0 || w0 >= n) continue;
         a = 256'(sum_all) * 256'(w0);
         b = 256'(n) * 256'(m0);
         diff = (a >= b) ? a - b : b - a;
         num = diff * diff;
         den = 256'(w0 * (n - w0));
         if (num * best_den > best_num * den) begin
            best_num = num;
            best_den = den;
            best = byte_type'(k);
         end
      end
      return best;
   endfunction

   function automatic void predict_request(input pixel_req_type r);
      mask_result_type res;
      byte_type        t;
      case (r.code)
         REQ_ACC: begin
            count_byte(r.a);
            count_byte(r.b);
            count_byte(r.c);
            if (pixel_total > CNT_MAX - CNT_W'(3)) pixel_total = CNT_MAX;
            else pixel_total = pixel_total + CNT_W'(3);
         end
         REQ_CALC: begin
            thr_model = (preset_model != 0) ? preset_model : otsu_search();
            for (int k = 0; k < NUM_BINS; k++) hist_model[k] = '0;
            pixel_total = '0;
            res.kind = KIND_THR;
            res.value = thr_model;
            expected_results.insert(expected_results.size(), res);
         end
         REQ_APPLY: begin
            t = (preset_model != 0) ? preset_model : thr_model;
            res.kind = KIND_PIX;
            res.value = (r.b > t) ? r.a : '0;
            expected_results.insert(expected_results.size(), res);
         end
         default: ;
      endcase
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) predict_request(cur_req);
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_req = pending_reqs.pop_front();
               req_bus.valid    <= 1'b1;
               req_bus.req_type <= cur_req.code;
               req_bus.chan_a   <= cur_req.a;
               req_bus.chan_b   <= cur_req.b;
               req_bus.chan_c   <= cur_req.c;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // receiver with one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         hold_left = 0;
         hold_done = 1'b0;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (hold_left != 0) begin
            hold_left--;
         end else if (hold_arm && !hold_done) begin
            hold_left = 400;
            hold_done = 1'b1;
         end
         rsp_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // response monitor
   always @(posedge clock) begin
      mask_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected response, value", int'(rsp_bus.out_value), -1);
         end else begin
            want = expected_results.pop_front();
            if (rsp_bus.result_kind !== want.kind)
               report_mismatch("result_kind", int'(rsp_bus.result_kind), int'(want.kind));
            if (rsp_bus.out_value !== want.value)
               report_mismatch("out_value", int'(rsp_bus.out_value), int'(want.value));
         end
      end
   end

   task automatic add_req(input req_code_type code, input int a, input int b, input int c);
      pixel_req_type r;
      r.code = code;
      r.a = byte_type'(a);
      r.b = byte_type'(b);
      r.c = byte_type'(c);
      pending_reqs.insert(pending_reqs.size(), r);
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() != 0 || req_bus.valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_preset(input byte_type v);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= v;
      do @(posedge clock); while (!csr_bus.ready);
      preset_model = v;
      csr_bus.valid <= 1'b0;
   endtask

   // one image: a few pixels in a band, the search, then masked pixels
   task automatic add_image();
      int npix, base, spread;
      npix = $urandom_range(40, 2);
      spread = ($urandom_range(9) == 0) ? 255 : $urandom_range(40);
      base = $urandom_range(255 - spread);
      repeat (npix)
         add_req(REQ_ACC, base + $urandom_range(spread), base + $urandom_range(spread),
                 base + $urandom_range(spread));
      add_req(REQ_CALC, $urandom_range(255), $urandom_range(255), $urandom_range(255));
      repeat ($urandom_range(25, 4))
         add_req(REQ_APPLY, $urandom_range(255), $urandom_range(255), $urandom_range(255));
   endtask

   task automatic add_random_phase(input int count);
      int goal;
      goal = pending_reqs.size() + count;
      while (pending_reqs.size() < goal) begin
         if ($urandom_range(99) < 85) begin
            add_image();
         end else if ($urandom_range(29) == 0) begin
            add_req(REQ_CALC, $urandom_range(255), $urandom_range(255), $urandom_range(255));
         end else begin
            add_req(($urandom_range(3) == 1) ? REQ_NOP : req_code_type'($urandom_range(3)),
                    $urandom_range(255), $urandom_range(255), $urandom_range(255));
         end
      end
   endtask

   initial begin
      byte_type phase_preset [4];
      int       send_pcts [4];
      int       rsp_pcts [4];
      error_count = 0;
      hold_arm = 1'b0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      preset_model = '0;
      thr_model = '0;
      pixel_total = '0;
      for (int k = 0; k < NUM_BINS; k++) hist_model[k] = '0;
      req_bus.valid = 1'b0;
      req_bus.req_type = REQ_ACC;
      req_bus.chan_a = '0;
      req_bus.chan_b = '0;
      req_bus.chan_c = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.data = '0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      write_preset(8'd0);
      // directed
      add_req(REQ_APPLY, 255, 1, 0);
      add_req(REQ_APPLY, 255, 0, 0);
      add_req(REQ_CALC, 0, 0, 0);
      add_req(REQ_NOP, 255, 255, 255);
      add_req(REQ_ACC, 77, 77, 77);
      add_req(REQ_CALC, 0, 0, 0);
      add_req(REQ_ACC, 0, 0, 255);
      add_req(REQ_ACC, 255, 0, 255);
      add_req(REQ_ACC, 10, 200, 10);
      add_req(REQ_CALC, 0, 0, 0);
      add_req(REQ_APPLY, 255, 255, 0);
      add_req(REQ_APPLY, 170, 10, 0);
      add_req(REQ_APPLY, 85, 200, 0);
      add_req(REQ_NOP, 0, 0, 0);
      add_req(REQ_ACC, 100, 101, 102);
      add_req(REQ_ACC, 103, 104, 105);
      add_req(REQ_CALC, 0, 0, 0);
      add_req(REQ_APPLY, 200, 104, 0);
      wait_idle();
      write_preset(8'd1);
      add_req(REQ_ACC, 0, 128, 255);
      add_req(REQ_CALC, 0, 0, 0);
      add_req(REQ_APPLY, 9, 1, 0);
      add_req(REQ_APPLY, 9, 2, 0);
      wait_idle();

      phase_preset = '{8'd0, 8'd255, 8'd0, byte_type'($urandom_range(254, 1))};
      send_pcts = '{0, 47, 0, 15};
      rsp_pcts = '{0, 0, 47, 15};
      for (int p = 0; p < 4; p++) begin
         write_preset(phase_preset[p]);
         send_idle_pct = send_pcts[p];
         rsp_stall_pct = rsp_pcts[p];
         add_random_phase(370);
         if (p == 0) hold_arm = 1'b1;
         wait_idle();
      end

      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule
